FILE: rtl/threshold_peak_spike_detector_core_assert.svh
// Assertion macros shared by the checker of the threshold peak spike detector.
// Every macro expects signals named clk and arst_n in the scope where it is used.
`ifndef THRESHOLD_PEAK_SPIKE_DETECTOR_CORE_ASSERT_SVH
`define THRESHOLD_PEAK_SPIKE_DETECTOR_CORE_ASSERT_SVH

// same-cycle implication
`define TPSD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define TPSD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: rtl/tpsd_pkg.sv
// Shared constants for the threshold peak spike detector.
// No dependencies; used by the top level and its checker.
`default_nettype none

package tpsd_pkg;

	localparam int WINDOW_MAX_DEF    = 32;
	localparam int HISTORY_DEPTH_DEF = 64;
	localparam int SAMPLE_BITS_DEF   = 16;

	localparam int IDX_W     = 32;  // sample index width
	localparam int THRESH_W  = 16;
	localparam int WLEN_W    = 6;
	localparam int CFG_W     = 16;  // widest register
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd1;

	localparam logic signed [THRESH_W-1:0] THRESH_RESET = '0;
	localparam logic [WLEN_W-1:0]          WLEN_RESET   = 6'd16;

endpackage

`default_nettype wire

FILE: rtl/threshold_peak_spike_detector_core.sv
// Threshold peak spike detector: a sample is taken only in ST_IDLE, after the scan of the last one;
// a peak decision rescans buffered samples from the peak on through the history RAM read port,
// with an ST_FETCH step before each rescanned sample.
// A result is registered in ST_SCAN; input is taken while a result waits,
// a second result holds the scan. arst_n clears the scanner, threshold to 0, window to 16;
// the history RAM is not cleared (entries are read only after being written in the record).
`default_nettype none

module threshold_peak_spike_detector_core #(
	parameter int WINDOW_MAX    = tpsd_pkg::WINDOW_MAX_DEF,
	parameter int HISTORY_DEPTH = tpsd_pkg::HISTORY_DEPTH_DEF,
	parameter int SAMPLE_BITS   = tpsd_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	// [SAMPLE_BITS-1:0] sample, upper bits zero fill
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,
	input  wire logic                                   s_tlast,   // last_sample
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	// [31:0] peak_index, [32+SAMPLE_BITS-1:32] peak_value, upper bits zero fill
	output logic [((tpsd_pkg::IDX_W+SAMPLE_BITS+7)/8)*8-1:0] m_tdata,
	input  wire logic                                   cfg_we,
	input  wire logic [tpsd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [tpsd_pkg::CFG_W-1:0]             cfg_wdata
);

	localparam int HA_W  = $clog2(HISTORY_DEPTH);
	localparam int OUT_W = ((tpsd_pkg::IDX_W + SAMPLE_BITS + 7) / 8) * 8;
	localparam int WCAP  = (WINDOW_MAX < HISTORY_DEPTH - 1) ? WINDOW_MAX : HISTORY_DEPTH - 1;
	localparam int CMP_W = (SAMPLE_BITS > tpsd_pkg::THRESH_W) ? SAMPLE_BITS : tpsd_pkg::THRESH_W;
	localparam logic [HA_W-1:0] SLOT_LAST = HA_W'(HISTORY_DEPTH - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FETCH} fsm_t;
	typedef enum logic [1:0] {
		MODE_SEEK    = 2'd0,
		MODE_COLLECT = 2'd1,
		MODE_SKIP    = 2'd2
	} scan_mode_t;

	fsm_t       state_q;
	scan_mode_t mode_q;
	scan_mode_t nx_mode;

	logic [tpsd_pkg::IDX_W-1:0]         count_q;
	logic [HA_W-1:0]                    wr_slot_q;
	logic [tpsd_pkg::IDX_W-1:0]         trig_q;
	logic [tpsd_pkg::IDX_W-1:0]         best_idx_q;
	logic signed [SAMPLE_BITS-1:0]      best_val_q;
	logic [HA_W-1:0]                    best_slot_q;
	logic [tpsd_pkg::IDX_W-1:0]         cur_idx_q;
	logic [HA_W-1:0]                    cur_slot_q;
	logic signed [SAMPLE_BITS-1:0]      samp_q;
	logic                               last_q;
	logic                               from_ram_q;
	logic                               emitted_q;
	logic                               out_valid_q;
	logic [tpsd_pkg::IDX_W-1:0]         out_idx_q;
	logic signed [SAMPLE_BITS-1:0]      out_val_q;
	logic signed [tpsd_pkg::THRESH_W-1:0] thresh_q;
	logic [tpsd_pkg::WLEN_W-1:0]        wlen_q;

	logic [SAMPLE_BITS-1:0]             ram_rdata;
	logic signed [SAMPLE_BITS-1:0]      cur_val;
	logic signed [CMP_W-1:0]            cur_ext;
	logic signed [CMP_W-1:0]            thr_ext;
	logic                               above;
	logic [tpsd_pkg::WLEN_W-1:0]        weff;
	logic [tpsd_pkg::IDX_W-1:0]         eff_trig;
	logic [tpsd_pkg::IDX_W-1:0]         eff_best_idx;
	logic signed [SAMPLE_BITS-1:0]      eff_best_val;
	logic [HA_W-1:0]                    eff_best_slot;
	logic                               collect;
	logic                               decide;
	logic                               hit;
	logic                               emit;
	logic                               stall;
	logic                               at_end;
	logic                               rec_end;
	logic                               in_xfer;
	logic [HA_W-1:0]                    cur_slot_inc;
	logic [HA_W-1:0]                    wr_slot_inc;

	assign s_tready = (state_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_val_q, out_idx_q});

	tpsd_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (in_xfer),
		.waddr (wr_slot_q),
		.wdata (s_tdata[SAMPLE_BITS-1:0]),
		.raddr (cur_slot_q),
		.rdata (ram_rdata)
	);

	assign cur_val = from_ram_q ? signed'(ram_rdata) : samp_q;
	assign cur_ext = CMP_W'(cur_val);
	assign thr_ext = CMP_W'(thresh_q);
	assign above   = cur_ext > thr_ext;
	assign weff    = (32'(wlen_q) > 32'(WCAP)) ? tpsd_pkg::WLEN_W'(WCAP) : wlen_q;
	assign at_end  = (cur_idx_q == count_q);

	assign cur_slot_inc = (cur_slot_q == SLOT_LAST) ? '0 : cur_slot_q + 1'b1;
	assign wr_slot_inc  = (wr_slot_q == SLOT_LAST) ? '0 : wr_slot_q + 1'b1;

	// one scanner step over the sample at cur_idx_q
	always_comb begin
		nx_mode       = mode_q;
		eff_trig      = trig_q;
		eff_best_idx  = best_idx_q;
		eff_best_val  = best_val_q;
		eff_best_slot = best_slot_q;
		collect       = 1'b0;
		decide        = 1'b0;
		hit           = 1'b0;
		case (mode_q)
			MODE_SKIP: begin
				if (!above) begin
					nx_mode = MODE_SEEK;
				end
			end
			MODE_COLLECT: begin
				collect = 1'b1;
			end
			default: begin
				if (!above) begin
					nx_mode = MODE_SEEK;
				end else begin
					eff_trig      = cur_idx_q;
					eff_best_idx  = cur_idx_q;
					eff_best_val  = cur_val;
					eff_best_slot = cur_slot_q;
					nx_mode       = MODE_COLLECT;
					collect       = 1'b1;
				end
			end
		endcase
		if (collect) begin
			if ((cur_idx_q - eff_trig) < 32'(weff)) begin
				if (cur_val > eff_best_val) begin
					eff_best_idx  = cur_idx_q;
					eff_best_val  = cur_val;
					eff_best_slot = cur_slot_q;
				end
			end else begin
				nx_mode = MODE_SKIP;
				decide  = 1'b1;
				hit     = eff_best_val > cur_val;
			end
		end
	end

	assign emit    = decide && hit && !emitted_q;
	assign stall   = emit && out_valid_q && !m_tready;
	// scan reached the final sample of the record with no decision pending
	assign rec_end = !decide && at_end && last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= tpsd_pkg::THRESH_RESET;
			wlen_q   <= tpsd_pkg::WLEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				tpsd_pkg::REG_THRESHOLD:     thresh_q <= cfg_wdata[tpsd_pkg::THRESH_W-1:0];
				tpsd_pkg::REG_WINDOW_LENGTH: wlen_q   <= cfg_wdata[tpsd_pkg::WLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_SEEK;
			count_q     <= '0;
			wr_slot_q   <= '0;
			trig_q      <= '0;
			best_idx_q  <= '0;
			best_val_q  <= '0;
			best_slot_q <= '0;
			cur_idx_q   <= '0;
			cur_slot_q  <= '0;
			samp_q      <= '0;
			last_q      <= 1'b0;
			from_ram_q  <= 1'b0;
			emitted_q   <= 1'b0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_val_q   <= '0;
		end else begin
			if (m_tready && !((state_q == ST_SCAN) && emit)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						samp_q     <= signed'(s_tdata[SAMPLE_BITS-1:0]);
						last_q     <= s_tlast;
						cur_idx_q  <= count_q;
						cur_slot_q <= wr_slot_q;
						from_ram_q <= 1'b0;
						emitted_q  <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_FETCH: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (!stall) begin
						mode_q      <= rec_end ? MODE_SEEK : nx_mode;
						trig_q      <= rec_end ? '0 : eff_trig;
						best_idx_q  <= rec_end ? '0 : eff_best_idx;
						best_val_q  <= rec_end ? '0 : eff_best_val;
						best_slot_q <= rec_end ? '0 : eff_best_slot;
						if (emit) begin
							out_valid_q <= 1'b1;
							out_idx_q   <= eff_best_idx;
							out_val_q   <= eff_best_val;
							emitted_q   <= 1'b1;
						end
						if (decide) begin
							// restart from the peak over buffered samples
							cur_idx_q  <= eff_best_idx;
							cur_slot_q <= eff_best_slot;
							from_ram_q <= 1'b1;
							state_q    <= ST_FETCH;
						end else if (at_end) begin
							state_q <= ST_IDLE;
							if (last_q) begin
								count_q   <= '0;
								wr_slot_q <= '0;
							end else begin
								count_q   <= count_q + 1'b1;
								wr_slot_q <= wr_slot_inc;
							end
						end else begin
							cur_idx_q  <= cur_idx_q + 1'b1;
							cur_slot_q <= cur_slot_inc;
							from_ram_q <= 1'b1;
							state_q    <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: rtl/tpsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the sample history of the detector.
`default_nettype none

module tpsd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/tpsd_checker.sv
// Port-level checker for the threshold peak spike detector, bound to the top level.
// Depends on tpsd_pkg and threshold_peak_spike_detector_core_assert.svh.
`default_nettype none

`include "threshold_peak_spike_detector_core_assert.svh"

module tpsd_checker #(
	parameter int SAMPLE_BITS = tpsd_pkg::SAMPLE_BITS_DEF
) (
	input wire logic                                            clk,
	input wire logic                                            arst_n,
	input wire logic                                            s_tvalid,
	input wire logic                                            s_tready,
	input wire logic                                            m_tvalid,
	input wire logic                                            m_tready,
	input wire logic [((tpsd_pkg::IDX_W+SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

	// a stalled result holds
	`TPSD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// one sample in work at a time
	`TPSD_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input taken while a sample is in work")

	// a new result only comes out of a scan cycle, never straight from idle
	`TPSD_ASSERT_SAME(a_result_from_scan, $rose(m_tvalid), !$past(s_tready), "result appeared without a scan")

endmodule

bind threshold_peak_spike_detector_core tpsd_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_tpsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
